/* rtl/core/bdlp_pkg.sv */
`default_nettype none
package bdlp_pkg;

  // fixed field widths
  localparam int unsigned PIN_W    = 2;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CODE_W   = 2;

  // item kinds carried in tuser
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // key codes
  localparam logic [CODE_W-1:0] KEY_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] KEY_SHORT = 2'd1;
  localparam logic [CODE_W-1:0] KEY_LONG  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ACTIVE_LEVELS = 2'd0;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;
  localparam logic [1:0] REG_LONG_SAMPLES  = 2'd2;

  // register reset values
  localparam logic [PIN_W-1:0]    ACTIVE_LEVELS_RST = 2'd0;
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 8'd10;
  localparam logic [COUNT_W-1:0]  LONG_SAMPLES_RST  = 16'd100;

  // prescaler status toward the top
  typedef struct packed {
    logic sample;
    logic busy;
  } presc_status_t;

  // per-button flags toward the merge stage
  typedef struct packed {
    logic new_key;
    logic long_flag;
  } lane_status_t;

endpackage
`default_nettype wire

/* rtl/core/bdlp_prescale.sv */
`default_nettype none
module bdlp_prescale (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              tick,
  input  wire                              period_write,
  input  wire [bdlp_pkg::PERIOD_W-1:0]     sample_period,
  output bdlp_pkg::presc_status_t          status
);
  import bdlp_pkg::*;

  localparam int unsigned STEP_W = $clog2(PERIOD_W + 1);

  logic [PERIOD_W-1:0] prescale_count;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   count_inc;
  logic [PERIOD_W-1:0] count_next;
  logic [STEP_W-1:0]   step_count;
  logic [PERIOD_W-1:0] div_src;
  logic [PERIOD_W-1:0] div_rem;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W-1:0] rem_next;

  // zero period behaves as one
  assign period = (sample_period == '0) ? PERIOD_W'(1) : sample_period;

  // count wraps at the period
  always_comb begin
    count_inc = {1'b0, prescale_count} + (PERIOD_W+1)'(1);
    if (count_inc == {1'b0, period}) begin
      count_next = '0;
    end else begin
      count_next = count_inc[PERIOD_W-1:0];
    end
  end

  // one restoring remainder step per cycle
  always_comb begin
    trial = {div_rem, div_src[PERIOD_W-1]};
    if (trial >= {1'b0, period}) begin
      rem_next = PERIOD_W'(trial - {1'b0, period});
    end else begin
      rem_next = trial[PERIOD_W-1:0];
    end
  end

  // count register and remainder sequencer after a period change
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      step_count     <= '0;
    end else if (period_write) begin
      step_count <= STEP_W'(PERIOD_W);
      div_src    <= prescale_count;
      div_rem    <= '0;
    end else if (step_count != '0) begin
      step_count <= step_count - STEP_W'(1);
      div_src    <= {div_src[PERIOD_W-2:0], 1'b0};
      div_rem    <= rem_next;
      if (step_count == STEP_W'(1)) begin
        prescale_count <= rem_next;
      end
    end else if (tick) begin
      prescale_count <= count_next;
    end
  end

  assign status.busy   = (step_count != '0);
  assign status.sample = tick && (count_next == period - PERIOD_W'(1));

endmodule
`default_nettype wire

/* rtl/core/bdlp_lane.sv */
`default_nettype none
module bdlp_lane (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             sample,
  input  wire                             pin,
  input  wire                             pressed,
  input  wire [bdlp_pkg::COUNT_W-1:0]     long_press_samples,
  input  wire                             clear_new,
  output bdlp_pkg::lane_status_t          status
);
  import bdlp_pkg::*;

  // the oldest sample is the middle one shifted out, so two registers
  // plus the incoming pin make up the three-sample window
  logic               sample_newest;
  logic               sample_middle;
  logic               stable_level;
  logic               new_key_flag;
  logic               long_flag;
  logic [COUNT_W-1:0] press_countdown;

  logic               stable_next;
  logic               new_key_next;
  logic               long_next;
  logic [COUNT_W-1:0] countdown_next;
  logic               settled;

  // all three samples agree on a level other than the stable one
  assign settled = (pin == sample_newest) && (sample_newest == sample_middle) &&
                   (pin != stable_level);

  // state update at a sample
  always_comb begin
    stable_next    = stable_level;
    new_key_next   = new_key_flag;
    long_next      = long_flag;
    countdown_next = press_countdown;
    if (press_countdown != '0) begin
      countdown_next = press_countdown - COUNT_W'(1);
      if (press_countdown == COUNT_W'(1)) begin
        long_next = 1'b1;
      end
    end
    if (settled) begin
      stable_next = pin;
      if (pin == pressed) begin
        countdown_next = long_press_samples;
      end else begin
        if (countdown_next != '0) begin
          new_key_next = 1'b1;
        end else begin
          long_next = 1'b0;
        end
        countdown_next = '0;
      end
    end
  end

  // history and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_newest   <= 1'b1;
      sample_middle   <= 1'b1;
      stable_level    <= 1'b1;
      new_key_flag    <= 1'b0;
      long_flag       <= 1'b0;
      press_countdown <= '0;
    end else if (sample) begin
      sample_middle   <= sample_newest;
      sample_newest   <= pin;
      stable_level    <= stable_next;
      new_key_flag    <= new_key_next;
      long_flag       <= long_next;
      press_countdown <= countdown_next;
    end else if (clear_new) begin
      new_key_flag <= 1'b0;
    end
  end

  assign status.new_key   = new_key_flag;
  assign status.long_flag = long_flag;

endmodule
`default_nettype wire

/* rtl/core/button_debounce_long_press.sv */
`default_nettype none
// channel   dir  payload                                        handshake
// s_axis    in   tuser: kind; tdata: button, pin_levels         s_tvalid/s_tready
// m_axis    out  tdata: key_code, long_active                   m_tvalid/m_tready
// apb       in   active_levels @0, sample_period @4, long @8    psel/penable
//
// one beat per clock on the input while s_tready is high; a tick beat gives no result,
// a read gives one result, registered in the output register or, if that is held, in
// the one-deep skid behind it; s_tready drops while the skid holds a beat or the
// prescaler is busy; writing sample_period starts a remainder pass on the prescale
// count, during which s_tready is low
// synchronous reset clears all flags and counters; buttons start released
module button_debounce_long_press #(
  parameter int unsigned NUM_BUTTONS = 2
) (
  input  wire         clk,
  input  wire         rst,
  // slave side
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [0] button, [2:1] pin_levels, [7:3] zero
  input  wire         s_tuser,   // [0] kind
  // master side
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [1:0] key_code, [2] long_active, [7:3] zero
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bdlp_pkg::*;

  logic [PIN_W-1:0]    active_levels;
  logic [PERIOD_W-1:0] sample_period;
  logic [COUNT_W-1:0]  long_press_samples;

  logic                cfg_write;
  logic [1:0]          cfg_index;
  logic                in_beat;
  logic                tick_beat;
  logic                read_beat;
  logic                button;
  logic [PIN_W-1:0]    pin_levels;

  presc_status_t       presc;
  lane_status_t        lane_stat [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] lane_sel;

  logic [CODE_W-1:0]   res_code;
  logic                res_long;
  logic [CODE_W-1:0]   out_code;
  logic                out_long;
  logic                skid_valid;
  logic [CODE_W-1:0]   skid_code;
  logic                skid_long;

  // apb register file
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels      <= ACTIVE_LEVELS_RST;
      sample_period      <= SAMPLE_PERIOD_RST;
      long_press_samples <= LONG_SAMPLES_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_LEVELS: active_levels      <= pwdata[PIN_W-1:0];
        REG_SAMPLE_PERIOD: sample_period      <= pwdata[PERIOD_W-1:0];
        REG_LONG_SAMPLES:  long_press_samples <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_ACTIVE_LEVELS: prdata = 32'(active_levels);
      REG_SAMPLE_PERIOD: prdata = 32'(sample_period);
      REG_LONG_SAMPLES:  prdata = 32'(long_press_samples);
      default:           prdata = '0;
    endcase
  end

  // input beat decode
  assign s_tready   = !presc.busy && !skid_valid;
  assign in_beat    = s_tvalid && s_tready;
  assign tick_beat  = in_beat && (s_tuser == KIND_TICK);
  assign read_beat  = in_beat && (s_tuser == KIND_READ);
  assign button     = s_tdata[0];
  assign pin_levels = s_tdata[PIN_W:1];

  bdlp_prescale u_prescale (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick_beat),
    .period_write  (cfg_write && (cfg_index == REG_SAMPLE_PERIOD)),
    .sample_period (sample_period),
    .status        (presc)
  );

  // one lane per button; buttons past the pin field see level zero
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic pin_b;
    logic pressed_b;
    if (b < PIN_W) begin : g_pin
      assign pin_b     = pin_levels[b];
      assign pressed_b = active_levels[b];
    end else begin : g_nopin
      assign pin_b     = 1'b0;
      assign pressed_b = 1'b0;
    end
    assign lane_sel[b] = ({31'b0, button} == 32'(b));

    bdlp_lane u_lane (
      .clk                (clk),
      .rst                (rst),
      .sample             (presc.sample),
      .pin                (pin_b),
      .pressed            (pressed_b),
      .long_press_samples (long_press_samples),
      .clear_new          (read_beat && lane_sel[b]),
      .status             (lane_stat[b])
    );
  end

  // merge: pick the addressed lane, a missing button reads as no key
  always_comb begin
    res_code = KEY_NONE;
    res_long = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (lane_sel[b]) begin
        res_long = lane_stat[b].long_flag;
        if (lane_stat[b].new_key) begin
          res_code = KEY_SHORT;
        end else if (lane_stat[b].long_flag) begin
          res_code = KEY_LONG;
        end
      end
    end
  end

  // output register with one-deep skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && m_tready) begin
        out_code   <= skid_code;
        out_long   <= skid_long;
        skid_valid <= 1'b0;
      end else if (read_beat) begin
        if (m_tvalid && !m_tready) begin
          skid_code  <= res_code;
          skid_long  <= res_long;
          skid_valid <= 1'b1;
        end else begin
          out_code <= res_code;
          out_long <= res_long;
          m_tvalid <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'b0, out_long, out_code};

  // no beat taken during the remainder pass
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    presc.busy |-> !in_beat) else $error("input taken while prescaler busy");

  // skid only fills behind a held output
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid holds a beat with output empty");

  // samples come only from accepted ticks
  a_sample_tick: assert property (@(posedge clk) disable iff (rst)
    presc.sample |-> tick_beat) else $error("sample without tick beat");

  // a read with the output free shows its result next cycle
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    read_beat && (!m_tvalid || m_tready) && !skid_valid |=>
      m_tvalid && (out_code == $past(res_code)))
    else $error("read result not presented");

endmodule
`default_nettype wire
